### hw/rtl/iepas_pkg.sv
// Shared types, codes and constants of the input event packer.
package iepas_pkg;

	localparam int unsigned TYPE_W     = 16;
	localparam int unsigned CODE_W     = 16;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned PROD_W     = VALUE_W + SIZE_W;
	localparam int unsigned CNT_W      = $clog2(PROD_W);

	localparam logic [TYPE_W-1:0] EVT_SYNC = 16'h0000;
	localparam logic [TYPE_W-1:0] EVT_KEY  = 16'h0001;
	localparam logic [TYPE_W-1:0] EVT_REL  = 16'h0002;
	localparam logic [TYPE_W-1:0] EVT_ABS  = 16'h0003;
	localparam logic [TYPE_W-1:0] EVT_MSC  = 16'h0004;

	localparam logic [CODE_W-1:0] AXIS_X = 16'h0000;
	localparam logic [CODE_W-1:0] AXIS_Y = 16'h0001;

	localparam logic [LEN_W-1:0] EVENT_BYTES = 16'h0008;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN         = 3'd0,
		REG_X_RANGE       = 3'd1,
		REG_Y_MIN         = 3'd2,
		REG_Y_RANGE       = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5
	} iepas_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_MUL,
		ST_DIV,
		ST_LOAD
	} iepas_state_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  event_type;
		logic [CODE_W-1:0]  event_code;
		logic [VALUE_W-1:0] event_value;
		logic [LEN_W-1:0]   used_length;
	} iepas_in_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  report_type;
		logic [CODE_W-1:0]  report_code;
		logic [VALUE_W-1:0] report_value;
		logic               report_sync;
	} iepas_out_t;

	typedef struct packed {
		logic take;
		logic clamp;
		logic mul;
		logic div;
		logic load;
	} iepas_cmd_t;

	typedef struct packed {
		logic release_held;
		logic scale;
		logic div_last;
		logic out_free;
	} iepas_sts_t;

endpackage

### hw/rtl/iepas_ctrl.sv
// Controller state machine that sequences accept, clamp, multiply, divide and load.
module iepas_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  iepas_pkg::iepas_sts_t sts,
	output iepas_pkg::iepas_cmd_t cmd
);
	import iepas_pkg::*;

	iepas_state_t state_q;
	iepas_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.release_held) begin
					state_d = sts.scale ? ST_CLAMP : ST_LOAD;
				end
			end
			ST_CLAMP: state_d = ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_MUL:   cmd.mul   = 1'b1;
			ST_DIV:   cmd.div   = 1'b1;
			ST_LOAD:  cmd.load  = sts.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/iepas_dp.sv
// Datapath: configuration registers, held event, clamp, multiplier, divider and output register.
module iepas_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [iepas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iepas_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  iepas_pkg::iepas_in_t                 in_data,
	output iepas_pkg::iepas_out_t                out_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	input  iepas_pkg::iepas_cmd_t                cmd,
	output iepas_pkg::iepas_sts_t                sts
);
	import iepas_pkg::*;

	logic [VALUE_W-1:0] x_min_q, x_range_q, y_min_q, y_range_q;
	logic [SIZE_W-1:0]  width_q, height_q;

	logic [TYPE_W-1:0]  held_type_q;
	logic [CODE_W-1:0]  held_code_q;
	logic [VALUE_W-1:0] held_value_q;
	logic               held_valid_q;

	logic [TYPE_W-1:0]  wk_type_q;
	logic [CODE_W-1:0]  wk_code_q;
	logic [VALUE_W-1:0] wk_value_q;
	logic               wk_sync_q;
	logic               wk_scale_q;
	logic [VALUE_W-1:0] wk_lo_q;
	logic [VALUE_W-1:0] wk_span_q;
	logic [SIZE_W-1:0]  wk_size_q;

	logic [PROD_W-1:0]  quo_q;
	logic [VALUE_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;

	iepas_out_t out_q;
	logic       out_valid_q;

	logic               len_ok, is_sync, is_hold;
	logic               sel_x, sel_y;
	logic [VALUE_W-1:0] sel_lo, sel_span;
	logic [SIZE_W-1:0]  sel_size;
	logic [VALUE_W-1:0] diff;
	logic [VALUE_W:0]   rs;
	logic               ge;

	assign len_ok  = in_data.used_length == EVENT_BYTES;
	assign is_sync = in_data.event_type == EVT_SYNC;
	assign is_hold = (in_data.event_type == EVT_KEY) || (in_data.event_type == EVT_REL) ||
		(in_data.event_type == EVT_ABS) || (in_data.event_type == EVT_MSC);

	assign sel_x    = (held_type_q == EVT_ABS) && (held_code_q == AXIS_X);
	assign sel_y    = (held_type_q == EVT_ABS) && (held_code_q == AXIS_Y);
	assign sel_lo   = sel_x ? x_min_q : y_min_q;
	assign sel_span = sel_x ? x_range_q : y_range_q;
	assign sel_size = sel_x ? width_q : height_q;

	assign sts.release_held = len_ok && (is_sync || is_hold) && held_valid_q;
	assign sts.scale        = (sel_x || sel_y) && (sel_span != '0) && (sel_size != '0);
	assign sts.div_last     = cnt_q == DIV_LAST;
	assign sts.out_free     = !out_valid_q || out_ready;

	assign diff = wk_value_q - wk_lo_q;
	assign rs   = {rem_q, quo_q[PROD_W-1]};
	assign ge   = rs >= {1'b0, wk_span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q   <= '0;
			x_range_q <= '0;
			y_min_q   <= '0;
			y_range_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_MIN:         x_min_q   <= cfg_data;
				REG_X_RANGE:       x_range_q <= cfg_data;
				REG_Y_MIN:         y_min_q   <= cfg_data;
				REG_Y_RANGE:       y_range_q <= cfg_data;
				REG_SCREEN_WIDTH:  width_q   <= cfg_data[SIZE_W-1:0];
				REG_SCREEN_HEIGHT: height_q  <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_type_q  <= '0;
			held_code_q  <= '0;
			held_value_q <= '0;
			held_valid_q <= 1'b0;
		end else if (cmd.take && len_ok) begin
			if (is_hold) begin
				held_type_q  <= in_data.event_type;
				held_code_q  <= in_data.event_code;
				held_value_q <= in_data.event_value;
				held_valid_q <= 1'b1;
			end else if (is_sync) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && sts.release_held) begin
			wk_type_q  <= held_type_q;
			wk_code_q  <= held_code_q;
			wk_value_q <= held_value_q;
			wk_sync_q  <= is_sync;
			wk_scale_q <= sts.scale;
			wk_lo_q    <= sel_lo;
			wk_span_q  <= sel_span;
			wk_size_q  <= sel_size;
		end else if (cmd.clamp) begin
			if (wk_value_q < wk_lo_q) begin
				wk_value_q <= '0;
			end else if (diff > wk_span_q) begin
				wk_value_q <= wk_span_q;
			end else begin
				wk_value_q <= diff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= PROD_W'(wk_value_q) * PROD_W'(wk_size_q - SIZE_W'(1));
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div) begin
			rem_q <= ge ? VALUE_W'(rs - {1'b0, wk_span_q}) : rs[VALUE_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.report_type  <= wk_type_q;
			out_q.report_code  <= wk_code_q;
			out_q.report_value <= wk_scale_q ? quo_q[VALUE_W-1:0] : wk_value_q;
			out_q.report_sync  <= wk_sync_q;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

### hw/rtl/input_event_packer_with_axis_scaling_top.sv
// Top level of the input event packer with absolute-axis scaling.
// Each event is taken when the block is idle. An event that releases no held event leaves the
// block idle; one that releases an unscaled event goes on to load the output register, and one
// that releases a scaled X or Y event first passes the clamp step, one 32-by-16 multiply and a
// 48-step restoring divider that finds one quotient bit a cycle. A new event is accepted while
// the previous result still waits in the output register.
module input_event_packer_with_axis_scaling_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  iepas_pkg::iepas_in_t             in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output iepas_pkg::iepas_out_t            out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [iepas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iepas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import iepas_pkg::*;

	iepas_cmd_t cmd;
	iepas_sts_t sts;

	assign cfg_ready = 1'b1;

	iepas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iepas_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A result is only loaded when the output register is free or being emptied.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> sts.out_free)
		else $error("result loaded over an untaken transfer");

	// An event of the wrong length never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.used_length != EVENT_BYTES) |=> !cmd.load)
		else $error("dropped event produced a result");

	// Releasing a held event keeps the input closed until the result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && sts.release_held) |=> !in_ready)
		else $error("input reopened before the released event was loaded");

endmodule

### bench/input_event_packer_with_axis_scaling_top_test.sv
// Self-checking testbench for the input event packer with absolute-axis scaling.
module input_event_packer_with_axis_scaling_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import iepas_pkg::*;

	localparam logic [TYPE_W-1:0]    EVT_FIRST_UNKNOWN = EVT_MSC + 1'b1;
	localparam logic [CODE_W-1:0]    AXIS_NONE         = AXIS_Y + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI      = 3'd7;
	localparam int unsigned          SETTLE_CYCLES     = 64;
	localparam int unsigned          IDLE_PCT          = 17;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	iepas_in_t             in_data;
	logic                  out_valid;
	logic                  out_ready;
	iepas_out_t            out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [VALUE_W-1:0] axis_x_lo = '0;
	logic [VALUE_W-1:0] axis_x_span = '0;
	logic [VALUE_W-1:0] axis_y_lo = '0;
	logic [VALUE_W-1:0] axis_y_span = '0;
	logic [SIZE_W-1:0]  pix_w = '0;
	logic [SIZE_W-1:0]  pix_h = '0;

	logic [TYPE_W-1:0]  pend_type = '0;
	logic [CODE_W-1:0]  pend_code = '0;
	logic [VALUE_W-1:0] pend_value = '0;
	logic               pend_full = 1'b0;

	iepas_out_t pending_reports[$];
	int unsigned faults = 0;
	bit calm = 1'b0;

	input_event_packer_with_axis_scaling_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [VALUE_W-1:0] scale_to_screen(input logic [VALUE_W-1:0] v,
			input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] span,
			input logic [SIZE_W-1:0] size);
		logic [VALUE_W:0]   top;
		logic [VALUE_W-1:0] c;
		logic [63:0]        prod;
		if (span == '0 || size == '0)
			return v;
		top = {1'b0, lo} + {1'b0, span};
		c = v;
		if (v < lo)
			c = lo;
		else if ({1'b0, v} > top)
			c = top[VALUE_W-1:0];
		prod = 64'(c - lo) * 64'(size - 1'b1);
		return VALUE_W'(prod / 64'(span));
	endfunction

	task automatic pack_event(input iepas_in_t ev);
		iepas_out_t rep;
		if (ev.used_length != EVENT_BYTES || ev.event_type > EVT_MSC)
			return;
		if (pend_full) begin
			rep.report_type = pend_type;
			rep.report_code = pend_code;
			rep.report_value = pend_value;
			if (pend_type == EVT_ABS && pend_code == AXIS_X)
				rep.report_value = scale_to_screen(pend_value, axis_x_lo, axis_x_span, pix_w);
			else if (pend_type == EVT_ABS && pend_code == AXIS_Y)
				rep.report_value = scale_to_screen(pend_value, axis_y_lo, axis_y_span, pix_h);
			rep.report_sync = (ev.event_type == EVT_SYNC);
			pending_reports.push_back(rep);
		end
		pend_full = (ev.event_type != EVT_SYNC);
		if (ev.event_type != EVT_SYNC) begin
			pend_type = ev.event_type;
			pend_code = ev.event_code;
			pend_value = ev.event_value;
		end
	endtask

	task automatic send_event(input iepas_in_t ev);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pack_event(ev);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_X_MIN:         axis_x_lo = data;
			REG_X_RANGE:       axis_x_span = data;
			REG_Y_MIN:         axis_y_lo = data;
			REG_Y_RANGE:       axis_y_span = data;
			REG_SCREEN_WIDTH:  pix_w = data[SIZE_W-1:0];
			REG_SCREEN_HEIGHT: pix_h = data[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [31:0] x_lo, input logic [31:0] x_span,
			input logic [31:0] y_lo, input logic [31:0] y_span, input logic [31:0] w,
			input logic [31:0] h, input bit spare);
		if (spare)
			write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
		write_reg(REG_X_MIN, x_lo);
		write_reg(REG_X_RANGE, x_span);
		write_reg(REG_Y_MIN, y_lo);
		write_reg(REG_Y_RANGE, y_span);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every expected report has been taken, then allow the block to drain.
	task automatic settle();
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_setting(input logic [31:0] top);
		case ($urandom_range(5))
			0: return '0;
			1: return top;
			2: return $urandom_range(2000, 1);
			default: return $urandom_range(top);
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] near_window(input logic [VALUE_W-1:0] lo,
			input logic [VALUE_W-1:0] span);
		case ($urandom_range(4))
			0: return lo - $urandom_range(3);
			1: return lo + span + $urandom_range(3);
			2, 3: return lo + $urandom_range(span);
			default: return $urandom;
		endcase
	endfunction

	function automatic iepas_in_t random_event();
		iepas_in_t   ev;
		int unsigned pick;
		ev.event_code = 16'($urandom);
		ev.event_value = $urandom;
		ev.used_length = EVENT_BYTES;
		pick = $urandom_range(99);
		if (pick < 20) begin
			ev.event_type = EVT_SYNC;
		end else if (pick < 70) begin
			ev.event_type = EVT_ABS;
			pick = $urandom_range(19);
			if (pick < 9) begin
				ev.event_code = AXIS_X;
				ev.event_value = near_window(axis_x_lo, axis_x_span);
			end else if (pick < 18) begin
				ev.event_code = AXIS_Y;
				ev.event_value = near_window(axis_y_lo, axis_y_span);
			end
		end else if (pick < 82) begin
			case ($urandom_range(2))
				0: ev.event_type = EVT_KEY;
				1: ev.event_type = EVT_REL;
				default: ev.event_type = EVT_MSC;
			endcase
		end else if (pick < 92) begin
			ev.event_type = 16'($urandom_range(EVT_MSC));
			ev.event_code = 16'($urandom_range(AXIS_NONE));
			ev.used_length = 16'($urandom);
		end else begin
			ev.event_type = 16'($urandom_range(16'hFFFF, EVT_FIRST_UNKNOWN));
		end
		return ev;
	endfunction

	task automatic report_diff(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			faults++;
			$display("%0t: %s expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		iepas_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				faults++;
				$display("%0t: unexpected report, expected none, got %h", $time, out_data);
			end else begin
				want = pending_reports.pop_front();
				report_diff("report_type", 32'(want.report_type), 32'(out_data.report_type));
				report_diff("report_code", 32'(want.report_code), 32'(out_data.report_code));
				report_diff("report_value", want.report_value, out_data.report_value);
				report_diff("report_sync", 32'(want.report_sync), 32'(out_data.report_sync));
			end
		end
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	task automatic test_packet_rules();
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_KEY, 16'hFFFF, 32'hFFFF_FFFF, EVENT_BYTES});
		send_event('{EVT_REL, AXIS_Y, 32'd1, 16'h0000});
		send_event('{EVT_REL, AXIS_Y, 32'd2, EVENT_BYTES - 1'b1});
		send_event('{EVT_ABS, AXIS_X, 32'd3, 16'hFFFF});
		send_event('{EVT_FIRST_UNKNOWN, AXIS_X, 32'd4, EVENT_BYTES});
		send_event('{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, EVENT_BYTES});
		send_event('{EVT_REL, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_MSC, 16'h00AA, 32'h5555_AAAA, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_X, 32'd12345, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_Y, 32'd678, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_NONE, 32'd999, EVENT_BYTES});
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_X, 32'hFFFF_FFFF, EVENT_BYTES});
		in_valid <= 1'b0;
	endtask

	task automatic test_axis_scaling();
		settle();
		write_settings(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd100, 32'd1000, 32'hFFFF, 32'd480, 1'b1);
		send_event('{EVT_ABS, AXIS_Y, 32'd5, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_Y, 32'd5000, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_Y, 32'd600, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_X, 32'd0, EVENT_BYTES});
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		in_valid <= 1'b0;
		settle();
		write_settings(32'd0, 32'd10, 32'd0, 32'd0, 32'hABCD_0000, 32'd480, 1'b1);
		send_event('{EVT_ABS, AXIS_X, 32'd7, EVENT_BYTES});
		send_event('{EVT_ABS, AXIS_Y, 32'd7, EVENT_BYTES});
		send_event('{EVT_SYNC, AXIS_X, 32'd0, EVENT_BYTES});
		in_valid <= 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 12; p++) begin
			settle();
			case (p)
				0: write_settings('1, '1, '1, '1, '1, '1, 1'b0);
				1: write_settings('0, '0, '0, '0, '0, '0, 1'b1);
				default: write_settings(pick_setting('1), pick_setting('1), pick_setting('1),
					pick_setting('1), {16'($urandom), 16'(pick_setting(16'hFFFF))},
					{16'($urandom), 16'(pick_setting(16'hFFFF))}, (p % 3) == 0);
			endcase
			calm = (p == 2);
			repeat (150) send_event(random_event());
			in_valid <= 1'b0;
		end
		calm = 1'b0;
	endtask

	initial begin
		int unsigned guard;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_packet_rules();
		test_axis_scaling();
		test_random_traffic();

		guard = 0;
		while (pending_reports.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			faults++;
			$display("%0t: %0d expected reports never arrived", $time, pending_reports.size());
		end
		if (faults == 0)
			$display("[input_event_packer_with_axis_scaling_top] OK");
		else
			$display("[input_event_packer_with_axis_scaling_top] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: run timed out", $time);
		$display("[input_event_packer_with_axis_scaling_top] ERROR");
		$finish;
	end

endmodule
